@@ hw/rtl/fsqrt_pkg.sv @@
`default_nettype none
package fsqrt_pkg;
	localparam logic [31:0] QNAN_BITS = 32'h7fc00000;
	localparam logic [31:0] SIGN_MASK = 32'h80000000;
	localparam int RAD_W = 50;
	localparam int ROOT_W = 25;
	localparam int REM_W = 27;
	localparam int NUM_STEPS = 25;
	localparam int STEPS_PER_STAGE = 5;

	typedef struct packed {
		logic        special;
		logic [31:0] special_bits;
		logic [7:0]  out_exp;
	} fsqrt_side_t;
endpackage
`default_nettype wire

@@ hw/rtl/fsqrt_prep.sv @@
`default_nettype none
module fsqrt_prep (
	input  wire logic [31:0]              operand_bits,
	output fsqrt_pkg::fsqrt_side_t        side,
	output logic [fsqrt_pkg::RAD_W-1:0]   rad
);
	import fsqrt_pkg::*;

	logic [7:0]  expo;
	logic [4:0]  lead;
	logic [5:0]  sh;
	logic [9:0]  e2;
	logic [63:0] wide;

	assign expo = operand_bits[30:23];

	// leading one of a subnormal fraction
	always_comb begin
		lead = 5'd0;
		for (int i = 0; i < 23; i++) begin
			if (operand_bits[i]) begin
				lead = 5'(i);
			end
		end
	end

	always_comb begin
		side.special = 1'b0;
		side.special_bits = operand_bits;
		rad = '0;
		e2 = '0;
		sh = '0;
		wide = '0;
		if (operand_bits == 32'd0 || operand_bits == SIGN_MASK) begin
			side.special = 1'b1;
		end else if (expo == 8'hff || operand_bits[31]) begin
			side.special = 1'b1;
			side.special_bits = QNAN_BITS;
		end else if (expo != 8'd0) begin
			e2 = 10'(expo) - 10'd127;
			if (expo[0]) begin
				wide = {40'd0, 1'b1, operand_bits[22:0]} << 25;
			end else begin
				wide = {40'd0, 1'b1, operand_bits[22:0]} << 26;
				e2 = e2 - 10'd1;
			end
			rad = wide[RAD_W-1:0];
		end else begin
			if (lead[0]) begin
				e2 = 10'(lead) - 10'd149;
				sh = 6'd48 - 6'(lead);
			end else begin
				e2 = 10'(lead) - 10'd150;
				sh = 6'd49 - 6'(lead);
			end
			wide = {32'd0, operand_bits} << sh;
			rad = wide[RAD_W-1:0];
		end
		side.out_exp = 8'({e2[9], e2[9:1]} + 10'd127);
	end
endmodule
`default_nettype wire

@@ hw/rtl/fsqrt_stage.sv @@
`default_nettype none
module fsqrt_stage #(
	parameter int STEPS = fsqrt_pkg::STEPS_PER_STAGE
) (
	input  wire logic [fsqrt_pkg::RAD_W-1:0]  rad_in,
	input  wire logic [fsqrt_pkg::ROOT_W-1:0] root_in,
	input  wire logic [fsqrt_pkg::REM_W-1:0]  rem_in,
	output logic [fsqrt_pkg::RAD_W-1:0]       rad_out,
	output logic [fsqrt_pkg::ROOT_W-1:0]      root_out,
	output logic [fsqrt_pkg::REM_W-1:0]       rem_out
);
	import fsqrt_pkg::*;

	logic [REM_W-1:0] rem_v;
	logic [REM_W-1:0] trial;
	logic [ROOT_W-1:0] root_v;
	logic [RAD_W-1:0] rad_v;

	// restoring steps, one bit pair each, radicand shifts left
	always_comb begin
		rem_v = rem_in;
		root_v = root_in;
		rad_v = rad_in;
		trial = '0;
		for (int i = 0; i < STEPS; i++) begin
			rem_v = {rem_v[REM_W-3:0], rad_v[RAD_W-1:RAD_W-2]};
			rad_v = {rad_v[RAD_W-3:0], 2'b00};
			trial = {root_v[REM_W-3:0], 2'b01};
			if (trial <= rem_v) begin
				rem_v = rem_v - trial;
				root_v = {root_v[ROOT_W-2:0], 1'b1};
			end else begin
				root_v = {root_v[ROOT_W-2:0], 1'b0};
			end
		end
		rad_out = rad_v;
		root_out = root_v;
		rem_out = rem_v;
	end
endmodule
`default_nettype wire

@@ hw/rtl/float32_square_root.sv @@
// float32_square_root: ieee single-precision square root on raw bits
// input channel: operand_valid / operand_stall with operand_bits
// output channel: root_valid / root_stall with root_bits
// zeros pass through; negatives, nan and infinities give 7fc00000
// an accepted word passes the input stage and then the five root stages before root_valid
// throughput: one word per cycle while operand_stall is low; set by the five-stage pipeline of
// the 25-step restoring root, five bit pairs per stage, plus an
// input stage that aligns the significand
// stalls: root_stall holds the output word; a bubble is filled while
// the output holds, so operand_stall rises only when every stage is full
// reset clears all valid bits; no word is in flight after reset
`default_nettype none
module float32_square_root (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        operand_valid,
	output logic             operand_stall,
	input  wire logic [31:0] operand_bits,
	output logic             root_valid,
	input  wire logic        root_stall,
	output logic [31:0]      root_bits
);
	import fsqrt_pkg::*;

	localparam int NST = NUM_STEPS / STEPS_PER_STAGE;

	fsqrt_side_t        side_c;
	logic [RAD_W-1:0]   rad_c;
	logic               v_s1;
	fsqrt_side_t        side_s1;
	logic [RAD_W-1:0]   rad_s1;

	logic               v_q [NST];
	fsqrt_side_t        side_q [NST];
	logic [RAD_W-1:0]   rad_q [NST];
	logic [ROOT_W-1:0]  root_q [NST];
	logic [REM_W-1:0]   rem_q [NST];
	logic [RAD_W-1:0]   rad_n [NST];
	logic [ROOT_W-1:0]  root_n [NST];
	logic [REM_W-1:0]   rem_n [NST];
	logic               adv [NST+1];

	fsqrt_prep u_prep (
		.operand_bits(operand_bits),
		.side(side_c),
		.rad(rad_c)
	);

	// a stage advances when it is empty or its successor advances
	always_comb begin
		adv[NST] = !root_stall || !v_q[NST-1];
		for (int i = NST - 1; i >= 1; i--) begin
			adv[i] = adv[i+1] || !v_q[i-1];
		end
		adv[0] = adv[1] || !v_s1;
	end
	assign operand_stall = !adv[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv[0]) begin
			v_s1 <= operand_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (adv[0]) begin
			side_s1 <= side_c;
			rad_s1 <= rad_c;
		end
	end

	for (genvar g = 0; g < NST; g++) begin : g_st
		if (g == 0) begin : g_first
			fsqrt_stage #(.STEPS(STEPS_PER_STAGE)) u_st (
				.rad_in(rad_s1), .root_in('0), .rem_in('0),
				.rad_out(rad_n[g]), .root_out(root_n[g]), .rem_out(rem_n[g])
			);
		end else begin : g_rest
			fsqrt_stage #(.STEPS(STEPS_PER_STAGE)) u_st (
				.rad_in(rad_q[g-1]), .root_in(root_q[g-1]), .rem_in(rem_q[g-1]),
				.rad_out(rad_n[g]), .root_out(root_n[g]), .rem_out(rem_n[g])
			);
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[g] <= 1'b0;
			end else if (adv[g+1]) begin
				v_q[g] <= (g == 0) ? v_s1 : v_q[(g == 0) ? 0 : g-1];
			end
		end
		always_ff @(posedge clk) begin
			if (adv[g+1]) begin
				side_q[g] <= (g == 0) ? side_s1 : side_q[(g == 0) ? 0 : g-1];
				rad_q[g] <= rad_n[g];
				root_q[g] <= root_n[g];
				rem_q[g] <= rem_n[g];
			end
		end
	end

	logic [ROOT_W-1:0] rnd;
	assign rnd = ROOT_W'(root_q[NST-1] + ROOT_W'(root_q[NST-1][0]));
	assign root_valid = v_q[NST-1];
	assign root_bits = side_q[NST-1].special ? side_q[NST-1].special_bits
		: {1'b0, side_q[NST-1].out_exp, rnd[23:1]};
endmodule
`default_nettype wire
